/* rtl/core/vlrd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlrd_pkg
// types, codes and sizes shared by the varint length record deframer
// ----------------------------------------------------------------------------
package vlrd_pkg;

  localparam int LEN_BITS   = 24;
  localparam int COUNT_BITS = 16;

  localparam int BYTE_W    = 8;
  localparam int GROUP_W   = 7;
  localparam int SHIFT_W   = 5;
  localparam int SHIFT_MAX = (2 ** SHIFT_W) - 1;
  localparam int WIDE_W    = GROUP_W + SHIFT_MAX;
  localparam int GROUP_STEP = 7;
  localparam int MAXREC_W  = 16;
  localparam int OUT_LEN_W = 24;
  localparam int OUT_CNT_W = 16;

  localparam logic [BYTE_W-1:0] GROUP_MASK = 8'o177;
  localparam logic [BYTE_W-1:0] LAST_MASK  = 8'o200;
  localparam logic [MAXREC_W-1:0] MAXREC_RESET = '1;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_STOPPED = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    ST_RUN       = 3'd0,
    ST_CLEAN     = 3'd1,
    ST_TRUNC_HDR = 3'd2,
    ST_TRUNC_PAY = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_LIMIT     = 3'd5
  } status_e;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } item_t;

  typedef struct packed {
    phase_e                phase;
    logic [LEN_BITS-1:0]   length_accum;
    logic [SHIFT_W-1:0]    group_shift;
    logic [LEN_BITS-1:0]   bytes_left;
    logic [COUNT_BITS-1:0] count_done;
    status_e               held_status;
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    out_byte;
    logic                 is_payload;
    logic                 record_end;
    logic [OUT_LEN_W-1:0] record_length;
    logic [OUT_CNT_W-1:0] record_count;
    status_e              status;
  } result_t;

endpackage

/* rtl/core/varint_length_record_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_length_record_deframer
// splits a byte stream into records with little-endian 7-bit length headers
//
// channel  dir  handshake               payload
// in       in   in_valid_i/in_ready_o    in_byte_i, in_last_i
// out      out  out_valid_o/out_ready_i  out_byte_o .. out_status_o
// cfg      in   cfg_valid_i/cfg_ready_o  cfg_max_records_i
//
// one byte per cycle while the output is not stalled; a byte passes the input
// register and then the result register, and leaves when out_ready_i is high
// reset clears the parser state and sets max_records to 65535
// a stalled output holds its result while the input register still takes
// one more byte; parser state moves only when a result is loaded
// ----------------------------------------------------------------------------
module varint_length_record_deframer import vlrd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [BYTE_W-1:0]    in_byte_i,
  input  logic                 in_last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BYTE_W-1:0]    out_byte_o,
  output logic                 out_is_payload_o,
  output logic                 out_record_end_o,
  output logic [OUT_LEN_W-1:0] out_record_length_o,
  output logic [OUT_CNT_W-1:0] out_record_count_o,
  output logic [2:0]           out_status_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [MAXREC_W-1:0]  cfg_max_records_i
);

  logic                 item_valid;
  item_t                item;
  logic                 take;
  logic                 out_free;
  state_t               state_q, state_d;
  result_t              res_d, res_q;
  logic                 out_valid_q;
  logic [MAXREC_W-1:0]  max_records_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign take     = item_valid && out_free;

  vlrd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  vlrd_step u_step (
    .item_i        (item),
    .state_i       (state_q),
    .max_records_i (max_records_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_records_q <= MAXREC_RESET;
    end else if (cfg_valid_i) begin
      max_records_q <= cfg_max_records_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase        <= PH_HEADER;
      state_q.length_accum <= '0;
      state_q.group_shift  <= '0;
      state_q.bytes_left   <= '0;
      state_q.count_done   <= '0;
      state_q.held_status  <= ST_RUN;
      out_valid_q          <= 1'b0;
    end else begin
      if (take) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= item_valid;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_byte_o          = res_q.out_byte;
  assign out_is_payload_o    = res_q.is_payload;
  assign out_record_end_o    = res_q.record_end;
  assign out_record_length_o = res_q.record_length;
  assign out_record_count_o  = res_q.record_count;
  assign out_status_o        = res_q.status;

endmodule

/* rtl/core/vlrd_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlrd_in_stage
// input register; holds one byte transfer until the step stage takes it
// ----------------------------------------------------------------------------
module vlrd_in_stage import vlrd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              in_last_i,
  input  logic              take_i,
  output logic              item_valid_o,
  output item_t             item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.in_byte <= in_byte_i;
      item_q.in_last <= in_last_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* rtl/core/vlrd_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlrd_step
// per-byte parser update: next state and the result for one byte
// ----------------------------------------------------------------------------
module vlrd_step import vlrd_pkg::*; (
  input  item_t                item_i,
  input  state_t               state_i,
  input  logic [MAXREC_W-1:0]  max_records_i,
  output state_t               state_o,
  output result_t              result_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [GROUP_W-1:0]   grp;
  logic [WIDE_W-1:0]    wide;
  logic [LEN_BITS-1:0]  len;
  logic [LEN_BITS-1:0]  left_dec;
  logic [SHIFT_W:0]     shift_sum;
  logic [31:0]          len_ext;
  logic [31:0]          cnt_ext;
  logic                 start;
  logic                 at_limit;
  logic                 overflow;
  logic [LEN_BITS-1:0]  rlen;
  logic                 payload;
  logic                 rend;
  state_t               nxt;

  assign grp       = GROUP_W'(item_i.in_byte & GROUP_MASK);
  assign wide      = {{(WIDE_W-GROUP_W){1'b0}}, grp} << state_i.group_shift;
  assign len       = state_i.length_accum | wide[LEN_BITS-1:0];
  assign left_dec  = state_i.bytes_left - LEN_BITS'(1);
  assign shift_sum = {1'b0, state_i.group_shift} + (SHIFT_W+1)'(GROUP_STEP);
  assign start     = (state_i.group_shift == '0) && (state_i.length_accum == '0);
  assign at_limit  = start && ((MAXREC_W'(state_i.count_done) >= max_records_i
                     && (COUNT_BITS <= MAXREC_W || (state_i.count_done >> MAXREC_W) == '0))
                     || ((COUNT_BITS > MAXREC_W) && (state_i.count_done >> MAXREC_W) != '0)
                     || state_i.count_done == CountMax);
  assign overflow  = (32'(state_i.group_shift) >= LEN_BITS) || ((wide >> LEN_BITS) != '0);

  always_comb begin
    nxt     = state_i;
    rlen    = '0;
    payload = 1'b0;
    rend    = 1'b0;
    case (state_i.phase)
      PH_HEADER: begin
        if (at_limit) begin
          nxt.phase       = PH_STOPPED;
          nxt.held_status = ST_LIMIT;
        end else if (overflow) begin
          nxt.phase       = PH_STOPPED;
          nxt.held_status = ST_OVERFLOW;
        end else if ((item_i.in_byte & LAST_MASK) != '0) begin
          rlen = len;
          if (len == '0) begin
            rend             = 1'b1;
            nxt.count_done   = state_i.count_done + COUNT_BITS'(1);
            nxt.length_accum = '0;
            nxt.group_shift  = '0;
            nxt.bytes_left   = '0;
            if (item_i.in_last) begin
              nxt.phase       = PH_STOPPED;
              nxt.held_status = ST_CLEAN;
            end
          end else if (item_i.in_last) begin
            nxt.phase       = PH_STOPPED;
            nxt.held_status = ST_TRUNC_PAY;
          end else begin
            nxt.phase        = PH_PAYLOAD;
            nxt.bytes_left   = len;
            nxt.length_accum = '0;
            nxt.group_shift  = '0;
          end
        end else if (item_i.in_last) begin
          nxt.phase       = PH_STOPPED;
          nxt.held_status = ST_TRUNC_HDR;
        end else begin
          nxt.length_accum = len;
          if (shift_sum > (SHIFT_W+1)'(SHIFT_MAX)) begin
            nxt.group_shift = SHIFT_W'(SHIFT_MAX);
          end else begin
            nxt.group_shift = shift_sum[SHIFT_W-1:0];
          end
        end
      end
      PH_PAYLOAD: begin
        payload        = 1'b1;
        nxt.bytes_left = left_dec;
        if (left_dec == '0) begin
          rend             = 1'b1;
          nxt.count_done   = state_i.count_done + COUNT_BITS'(1);
          nxt.phase        = PH_HEADER;
          nxt.length_accum = '0;
          nxt.group_shift  = '0;
          if (item_i.in_last) begin
            nxt.phase       = PH_STOPPED;
            nxt.held_status = ST_CLEAN;
          end
        end else if (item_i.in_last) begin
          nxt.phase       = PH_STOPPED;
          nxt.held_status = ST_TRUNC_PAY;
        end
      end
      default: begin
      end
    endcase
  end

  assign len_ext = 32'(rlen);
  assign cnt_ext = 32'(nxt.count_done);

  assign state_o                = nxt;
  assign result_o.out_byte      = item_i.in_byte;
  assign result_o.is_payload    = payload;
  assign result_o.record_end    = rend;
  assign result_o.record_length = len_ext[OUT_LEN_W-1:0];
  assign result_o.record_count  = cnt_ext[OUT_CNT_W-1:0];
  assign result_o.status        = (nxt.phase == PH_STOPPED) ? nxt.held_status : ST_RUN;

endmodule
